/* sv/mcvm_pkg.sv */
// ----------------------------------------------------------------------------
// mcvm_pkg
// Types, constants and fixed-point helpers shared by the motor current and
// voltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package mcvm_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 16;
	localparam int QW            = SAMPLE_BITS + FRACTION_BITS;
	localparam int COEF_W        = FRACTION_BITS;
	localparam int TRACK_PW      = QW + COEF_W;

	localparam int MV_W          = 17;
	localparam int MA_W          = 21;
	localparam int MAV_W         = 22;
	localparam int MA_MAG_W      = MA_W - 1;
	localparam int MV_SCALE_W    = 17;
	localparam int MA_SCALE_W    = 20;
	localparam int MV_PW         = SAMPLE_BITS + MV_SCALE_W;
	localparam int MA_PW         = QW + MA_SCALE_W;

	localparam int PADDR_W       = 5;
	localparam int PDATA_W       = 32;

	localparam logic [MV_SCALE_W-1:0] MV_SCALE = MV_SCALE_W'(98000);
	localparam logic [MA_SCALE_W-1:0] MA_SCALE = MA_SCALE_W'(1000000);

	// filter and offset coefficients, rounded to the nearest fraction count
	localparam logic [COEF_W-1:0] COEF_DC     = COEF_W'(((1 << FRACTION_BITS) + 100) / 200);
	localparam logic [COEF_W-1:0] COEF_VBUS   = COEF_W'(((1 << FRACTION_BITS) + 1) / 2);
	localparam logic [COEF_W-1:0] COEF_OFFSET = COEF_W'(((1 << FRACTION_BITS) + 50) / 100);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [QW-1:0]          q_t;

	localparam q_t Q_MAX     = {{SAMPLE_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};
	localparam q_t Q_MID     = {1'b1, {(QW-1){1'b0}}};
	localparam q_t DCF_RESET = QW'(64'd2000 << FRACTION_BITS);
	localparam q_t VBF_RESET = QW'(64'd2500 << FRACTION_BITS);
	localparam sample_t S_MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic {
		OP_MEASURE   = 1'b0,
		OP_CALIBRATE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		FAULT_NONE      = 3'd0,
		FAULT_DC        = 3'd1,
		FAULT_OVERVOLT  = 3'd2,
		FAULT_UNDERVOLT = 3'd3,
		FAULT_PHASE     = 3'd4
	} fault_t;

	typedef enum logic [2:0] {
		REG_PHASE_HIGH = 3'd0,
		REG_PHASE_LOW  = 3'd1,
		REG_DC_HIGH    = 3'd2,
		REG_DC_LOW     = 3'd3,
		REG_OVERVOLT   = 3'd4,
		REG_UNDERVOLT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		op_t     op;
		logic    vbus_ready;
		sample_t vbus_sample;
		logic    phase_u_ready;
		sample_t phase_u_sample;
		logic    phase_w_ready;
		sample_t phase_w_sample;
		logic    dc_ready;
		sample_t dc_sample;
	} item_t;

	typedef struct packed {
		sample_t phase_high;
		sample_t phase_low;
		sample_t dc_high;
		sample_t dc_low;
		sample_t overvolt;
		sample_t undervolt;
	} cfg_t;

	typedef struct packed {
		sample_t last_vbus;
		sample_t last_u;
		sample_t last_w;
		sample_t last_dc;
		q_t      off_u;
		q_t      off_w;
		q_t      off_dc;
		q_t      dc_filt;
		q_t      vbus_filt;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		phase_high: SAMPLE_BITS'(4000),
		phase_low:  SAMPLE_BITS'(100),
		dc_high:    SAMPLE_BITS'(4000),
		dc_low:     SAMPLE_BITS'(100),
		overvolt:   SAMPLE_BITS'(3000),
		undervolt:  SAMPLE_BITS'(2000)
	};

	localparam state_t ST_RESET = '{
		last_vbus: '0,
		last_u:    S_MID,
		last_w:    S_MID,
		last_dc:   S_MID,
		off_u:     Q_MID,
		off_w:     Q_MID,
		off_dc:    Q_MID,
		dc_filt:   DCF_RESET,
		vbus_filt: VBF_RESET
	};

	// f + coef * (x - f), product rounded half away from zero, clamped to full scale
	function automatic q_t track(q_t f, sample_t x, logic [COEF_W-1:0] coef);
		logic signed [QW:0]   d;
		logic [QW-1:0]        mag;
		logic [TRACK_PW-1:0]  prod;
		logic [TRACK_PW-1:0]  rnd;
		logic [QW-1:0]        r;
		logic signed [QW+1:0] step;
		logic signed [QW+1:0] sum;
		q_t                   res;
		d    = $signed({1'b0, x, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, f});
		mag  = QW'(d[QW] ? -d : d);
		prod = {{COEF_W{1'b0}}, mag} * {{QW{1'b0}}, coef};
		rnd  = prod + (TRACK_PW'(1) << (FRACTION_BITS - 1));
		r    = rnd[FRACTION_BITS +: QW];
		step = d[QW] ? -$signed({2'b00, r}) : $signed({2'b00, r});
		sum  = $signed({2'b00, f}) + step;
		if (sum < 0) begin
			res = '0;
		end else if (sum > $signed({2'b00, Q_MAX})) begin
			res = Q_MAX;
		end else begin
			res = sum[QW-1:0];
		end
		return res;
	endfunction

	// (raw - offset) scaled to milliamps, rounded half away from zero
	function automatic logic signed [MA_W-1:0] to_milliamps(sample_t raw, q_t off);
		logic signed [QW:0]  d;
		logic [QW-1:0]       mag;
		logic [MA_PW-1:0]    prod;
		logic [MA_PW-1:0]    rnd;
		logic [MA_MAG_W-1:0] r;
		d    = $signed({1'b0, raw, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, off});
		mag  = QW'(d[QW] ? -d : d);
		prod = {{MA_SCALE_W{1'b0}}, mag} * {{QW{1'b0}}, MA_SCALE};
		rnd  = prod + (MA_PW'(1) << (QW - 1));
		r    = rnd[QW +: MA_MAG_W];
		return d[QW] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	function automatic logic [MV_W-1:0] to_millivolts(sample_t raw);
		logic [MV_PW-1:0] prod;
		prod = {{MV_SCALE_W{1'b0}}, raw} * {{SAMPLE_BITS{1'b0}}, MV_SCALE};
		return prod[SAMPLE_BITS +: MV_W];
	endfunction

endpackage

`default_nettype wire

/* sv/mcvm_in_if.sv */
// ----------------------------------------------------------------------------
// mcvm_in_if
// Sample channel: one converter sample set with ready flags and an op code.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcvm_in_if;
	logic                       valid;
	logic                       ready;
	mcvm_pkg::op_t              op;
	logic                       vbus_ready;
	logic [mcvm_pkg::SAMPLE_BITS-1:0] vbus_sample;
	logic                       phase_u_ready;
	logic [mcvm_pkg::SAMPLE_BITS-1:0] phase_u_sample;
	logic                       phase_w_ready;
	logic [mcvm_pkg::SAMPLE_BITS-1:0] phase_w_sample;
	logic                       dc_ready;
	logic [mcvm_pkg::SAMPLE_BITS-1:0] dc_sample;

	modport source (
		output valid, op, vbus_ready, vbus_sample, phase_u_ready, phase_u_sample,
		       phase_w_ready, phase_w_sample, dc_ready, dc_sample,
		input  ready
	);
	modport sink (
		input  valid, op, vbus_ready, vbus_sample, phase_u_ready, phase_u_sample,
		       phase_w_ready, phase_w_sample, dc_ready, dc_sample,
		output ready
	);
endinterface

`default_nettype wire

/* sv/mcvm_out_if.sv */
// ----------------------------------------------------------------------------
// mcvm_out_if
// Result channel: scaled bus voltage, currents and fault code.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcvm_out_if;
	logic                                valid;
	logic                                ready;
	logic [mcvm_pkg::MV_W-1:0]           vbus_millivolts;
	logic signed [mcvm_pkg::MA_W-1:0]    dc_milliamps;
	logic signed [mcvm_pkg::MA_W-1:0]    u_milliamps;
	logic signed [mcvm_pkg::MAV_W-1:0]   v_milliamps;
	logic signed [mcvm_pkg::MA_W-1:0]    w_milliamps;
	mcvm_pkg::fault_t                    fault;

	modport source (
		output valid, vbus_millivolts, dc_milliamps, u_milliamps, v_milliamps,
		       w_milliamps, fault,
		input  ready
	);
	modport sink (
		input  valid, vbus_millivolts, dc_milliamps, u_milliamps, v_milliamps,
		       w_milliamps, fault,
		output ready
	);
endinterface

`default_nettype wire

/* sv/motor_current_voltage_monitor.sv */
// ----------------------------------------------------------------------------
// motor_current_voltage_monitor
// Inverter bus voltage and phase / DC current monitor with filtering, offset
// calibration and prioritized fault reporting.
//
//   channel   role     handshake            contents
//   samples   sink     valid / ready        op, four ready flags, four samples
//   results   source   valid / ready        mV, DC / U / V / W mA, fault code
//   apb       slave    psel / penable       six 12-bit fault limits
//
// one transaction per cycle sustained while results are not stalled; each sample
// is registered in the input, state and result registers before it is presented
// stages: input register, state update (filter / offset step), result register
// a stalled result holds the state stage, which holds the input register
// reset loads the default limits, mid-scale offsets and filter start values
// ----------------------------------------------------------------------------
`default_nettype none

module motor_current_voltage_monitor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mcvm_in_if.sink                             samples,
	mcvm_out_if.source                          results,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mcvm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mcvm_pkg::PDATA_W-1:0]   pwdata,
	output logic [mcvm_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	mcvm_pkg::cfg_t   cfg;
	mcvm_pkg::item_t  item;
	mcvm_pkg::state_t st;
	logic             in_ready;
	logic             upd_valid;
	logic             upd_take;

	assign item = '{
		op:             samples.op,
		vbus_ready:     samples.vbus_ready,
		vbus_sample:    samples.vbus_sample,
		phase_u_ready:  samples.phase_u_ready,
		phase_u_sample: samples.phase_u_sample,
		phase_w_ready:  samples.phase_w_ready,
		phase_w_sample: samples.phase_w_sample,
		dc_ready:       samples.dc_ready,
		dc_sample:      samples.dc_sample
	};
	assign samples.ready = in_ready;

	mcvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mcvm_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (in_ready),
		.item      (item),
		.upd_valid (upd_valid),
		.upd_take  (upd_take),
		.st        (st)
	);

	mcvm_report u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_valid (upd_valid),
		.upd_take  (upd_take),
		.st        (st),
		.cfg       (cfg),
		.results   (results)
	);

endmodule

`default_nettype wire

/* sv/mcvm_regs.sv */
// ----------------------------------------------------------------------------
// mcvm_regs
// APB register file holding the six fault limits.
// ----------------------------------------------------------------------------
`default_nettype none

module mcvm_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mcvm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mcvm_pkg::PDATA_W-1:0]   pwdata,
	output logic [mcvm_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	output mcvm_pkg::cfg_t                      cfg
);

	mcvm_pkg::cfg_t      cfg_q;
	mcvm_pkg::reg_idx_t  idx;
	mcvm_pkg::sample_t   wval;
	mcvm_pkg::sample_t   rval;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = mcvm_pkg::reg_idx_t'(paddr[mcvm_pkg::PADDR_W-1:2]);
	assign wval   = pwdata[mcvm_pkg::SAMPLE_BITS-1:0];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mcvm_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mcvm_pkg::REG_PHASE_HIGH: cfg_q.phase_high <= wval;
				mcvm_pkg::REG_PHASE_LOW:  cfg_q.phase_low  <= wval;
				mcvm_pkg::REG_DC_HIGH:    cfg_q.dc_high    <= wval;
				mcvm_pkg::REG_DC_LOW:     cfg_q.dc_low     <= wval;
				mcvm_pkg::REG_OVERVOLT:   cfg_q.overvolt   <= wval;
				mcvm_pkg::REG_UNDERVOLT:  cfg_q.undervolt  <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mcvm_pkg::REG_PHASE_HIGH: rval = cfg_q.phase_high;
			mcvm_pkg::REG_PHASE_LOW:  rval = cfg_q.phase_low;
			mcvm_pkg::REG_DC_HIGH:    rval = cfg_q.dc_high;
			mcvm_pkg::REG_DC_LOW:     rval = cfg_q.dc_low;
			mcvm_pkg::REG_OVERVOLT:   rval = cfg_q.overvolt;
			mcvm_pkg::REG_UNDERVOLT:  rval = cfg_q.undervolt;
			default:                  rval = '0;
		endcase
	end

	assign prdata = mcvm_pkg::PDATA_W'(rval);
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

/* sv/mcvm_update.sv */
// ----------------------------------------------------------------------------
// mcvm_update
// Input register and state update: latches samples, runs the DC and bus
// filters on a measure item and steps the current offsets on a calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module mcvm_update (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire mcvm_pkg::item_t  item,
	output logic                  upd_valid,
	input  wire logic             upd_take,
	output mcvm_pkg::state_t      st
);

	logic              valid_s1;
	mcvm_pkg::item_t   item_s1;
	logic              valid_s2;
	mcvm_pkg::state_t  st_q;
	mcvm_pkg::state_t  st_d;
	logic              s1_adv;
	mcvm_pkg::sample_t lat_vbus;
	mcvm_pkg::sample_t lat_u;
	mcvm_pkg::sample_t lat_w;
	mcvm_pkg::sample_t lat_dc;

	// state holds the last item until its report is captured
	assign s1_adv   = valid_s1 && (!valid_s2 || upd_take);
	assign in_ready = !valid_s1 || s1_adv;

	assign lat_vbus = item_s1.vbus_ready    ? item_s1.vbus_sample    : st_q.last_vbus;
	assign lat_u    = item_s1.phase_u_ready ? item_s1.phase_u_sample : st_q.last_u;
	assign lat_w    = item_s1.phase_w_ready ? item_s1.phase_w_sample : st_q.last_w;
	assign lat_dc   = item_s1.dc_ready      ? item_s1.dc_sample      : st_q.last_dc;

	always_comb begin
		st_d = st_q;
		unique case (item_s1.op)
			mcvm_pkg::OP_MEASURE: begin
				st_d.last_vbus = lat_vbus;
				st_d.last_u    = lat_u;
				st_d.last_w    = lat_w;
				st_d.last_dc   = lat_dc;
				st_d.dc_filt   = mcvm_pkg::track(st_q.dc_filt, lat_dc, mcvm_pkg::COEF_DC);
				st_d.vbus_filt = mcvm_pkg::track(st_q.vbus_filt, lat_vbus,
					mcvm_pkg::COEF_VBUS);
			end
			mcvm_pkg::OP_CALIBRATE: begin
				st_d.off_u  = mcvm_pkg::track(st_q.off_u, st_q.last_u, mcvm_pkg::COEF_OFFSET);
				st_d.off_w  = mcvm_pkg::track(st_q.off_w, st_q.last_w, mcvm_pkg::COEF_OFFSET);
				st_d.off_dc = mcvm_pkg::track(st_q.off_dc, st_q.last_dc,
					mcvm_pkg::COEF_OFFSET);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= mcvm_pkg::ST_RESET;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
				st_q     <= st_d;
			end else if (upd_take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

	assign upd_valid = valid_s2;
	assign st        = st_q;

	a_hold_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !upd_take |=> $stable(st_q))
		else $error("state changed before its report was taken");

	a_filters_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dc_filt <= mcvm_pkg::Q_MAX && st_q.vbus_filt <= mcvm_pkg::Q_MAX &&
		st_q.off_u <= mcvm_pkg::Q_MAX && st_q.off_w <= mcvm_pkg::Q_MAX &&
		st_q.off_dc <= mcvm_pkg::Q_MAX)
		else $error("filter or offset above full scale");

	a_calib_keeps_filters: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && item_s1.op == mcvm_pkg::OP_CALIBRATE |=>
		$stable(st_q.dc_filt) && $stable(st_q.vbus_filt) && $stable(st_q.last_dc))
		else $error("calibration touched filters or samples");

	a_measure_keeps_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && item_s1.op == mcvm_pkg::OP_MEASURE |=>
		$stable(st_q.off_u) && $stable(st_q.off_w) && $stable(st_q.off_dc))
		else $error("measure touched offsets");

endmodule

`default_nettype wire

/* sv/mcvm_report.sv */
// ----------------------------------------------------------------------------
// mcvm_report
// Scales the updated state to millivolts and milliamps, picks the fault code
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcvm_report (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              upd_valid,
	output logic                   upd_take,
	input  wire mcvm_pkg::state_t  st,
	input  wire mcvm_pkg::cfg_t    cfg,
	mcvm_out_if.source             results
);

	logic                                 out_valid_q;
	logic [mcvm_pkg::MV_W-1:0]            mv_q;
	logic signed [mcvm_pkg::MA_W-1:0]     dc_q;
	logic signed [mcvm_pkg::MA_W-1:0]     u_q;
	logic signed [mcvm_pkg::MAV_W-1:0]    v_q;
	logic signed [mcvm_pkg::MA_W-1:0]     w_q;
	mcvm_pkg::fault_t                     fault_q;

	logic signed [mcvm_pkg::MA_W-1:0]     u_ma;
	logic signed [mcvm_pkg::MA_W-1:0]     w_ma;
	logic signed [mcvm_pkg::MAV_W-1:0]    v_ma;
	mcvm_pkg::fault_t                     fault_d;
	logic                                 dc_bad;
	logic                                 phase_bad;

	assign upd_take = upd_valid && (!out_valid_q || results.ready);

	assign u_ma = mcvm_pkg::to_milliamps(st.last_u, st.off_u);
	assign w_ma = mcvm_pkg::to_milliamps(st.last_w, st.off_w);
	assign v_ma = -(mcvm_pkg::MAV_W'(u_ma) + mcvm_pkg::MAV_W'(w_ma));

	assign dc_bad =
		st.dc_filt > {cfg.dc_high, {mcvm_pkg::FRACTION_BITS{1'b0}}} ||
		st.dc_filt < {cfg.dc_low, {mcvm_pkg::FRACTION_BITS{1'b0}}};
	assign phase_bad =
		st.last_u > cfg.phase_high || st.last_w > cfg.phase_high ||
		st.last_u < cfg.phase_low  || st.last_w < cfg.phase_low;

	// highest code wins
	always_comb begin
		priority if (phase_bad) begin
			fault_d = mcvm_pkg::FAULT_PHASE;
		end else if (st.vbus_filt < {cfg.undervolt, {mcvm_pkg::FRACTION_BITS{1'b0}}}) begin
			fault_d = mcvm_pkg::FAULT_UNDERVOLT;
		end else if (st.last_vbus > cfg.overvolt) begin
			fault_d = mcvm_pkg::FAULT_OVERVOLT;
		end else if (dc_bad) begin
			fault_d = mcvm_pkg::FAULT_DC;
		end else begin
			fault_d = mcvm_pkg::FAULT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_take) begin
			mv_q    <= mcvm_pkg::to_millivolts(st.last_vbus);
			dc_q    <= mcvm_pkg::to_milliamps(st.last_dc, st.off_dc);
			u_q     <= u_ma;
			v_q     <= v_ma;
			w_q     <= w_ma;
			fault_q <= fault_d;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.vbus_millivolts = mv_q;
	assign results.dc_milliamps    = dc_q;
	assign results.u_milliamps     = u_q;
	assign results.v_milliamps     = v_q;
	assign results.w_milliamps     = w_q;
	assign results.fault           = fault_q;

	a_v_is_neg_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> v_q == -(mcvm_pkg::MAV_W'(u_q) + mcvm_pkg::MAV_W'(w_q)))
		else $error("phase V is not the negative sum of U and W");

	a_take_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		upd_take |=> out_valid_q)
		else $error("captured result not presented");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		upd_valid && !upd_take |-> out_valid_q && !results.ready)
		else $error("report stage stalled with room at the output");

endmodule

`default_nettype wire
